// ===== rtl/lfuc_pkg.sv =====
// Shared types, widths and codes for the use-count ordered record cache.
// Depends on nothing; used by rtl/lfu_ordered_record_cache_top.sv.
package lfuc_pkg;

  localparam int DEPTH       = 16;
  localparam int COUNT_WIDTH = 16;

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int OCC_W  = $clog2(DEPTH + 1);
  localparam int CAP_W  = 5;
  localparam int WIDE_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam int ACT_W  = 2;
  localparam int TAG_W  = 64;
  localparam int OFF_W  = 32;
  localparam int BODY_W = 64;
  localparam int RANK_W = 4;

  localparam logic [CAP_W-1:0]       CAP_RESET = 5'd16;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = {COUNT_WIDTH{1'b1}};

  // Action codes
  localparam logic [ACT_W-1:0] ACT_ADD      = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SRCH_TAG = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SRCH_OFF = 2'd2;

  typedef struct packed {
    logic [TAG_W-1:0]       tag;
    logic [OFF_W-1:0]       off;
    logic [BODY_W-1:0]      body;
    logic [COUNT_WIDTH-1:0] cnt;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RANK,
    ST_SHIFT,
    ST_PLACE,
    ST_RESP
  } state_t;

endpackage

// ===== rtl/lfu_ordered_record_cache_top.sv =====
// Use-count ordered record cache: top level with the entry memory and its sequencer.
// Depends on rtl/lfuc_pkg.sv.
//
// Usage
//   Input channel (in_valid / in_stall): one transaction is an add, a search by name
//   tag or a search by offset. A transaction is taken only while the sequencer is
//   idle; in_stall is high for the whole time one transaction is at work.
//   Result channel (out_valid / out_stall): exactly one result transaction per input
//   transaction, held in an output register until the receiver takes it. A stalled
//   receiver holds the finished result; the next input transaction is still taken
//   while that result waits, and its own result waits in the sequencer until the
//   output register is free.
//   Configuration (cfg_valid / cfg_ready / cfg_capacity): write the capacity while idle.
// Sequence
//   All entries live in one synchronous memory with one read and one write per cycle.
//   An add writes in its accept cycle, then presents its result. A search reads the
//   entries from the head to the first match, reads them again for the first lower
//   use count, then moves each displaced entry through the read port, writes the
//   matched entry and presents the result. Transactions are handled one at a time.
// Reset
//   Synchronous, active low: capacity returns to 16, occupancy to zero, the output
//   register empties. Memory contents are not cleared; only occupied entries are read.
module lfu_ordered_record_cache_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [lfuc_pkg::ACT_W-1:0]      in_action,
  input  logic [lfuc_pkg::TAG_W-1:0]      in_name_tag,
  input  logic [lfuc_pkg::OFF_W-1:0]      in_record_offset,
  input  logic [lfuc_pkg::BODY_W-1:0]     in_payload,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_found,
  output logic [lfuc_pkg::TAG_W-1:0]      out_found_name_tag,
  output logic [lfuc_pkg::OFF_W-1:0]      out_found_offset,
  output logic [lfuc_pkg::BODY_W-1:0]     out_found_payload,
  output logic [lfuc_pkg::RANK_W-1:0]     out_new_rank,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lfuc_pkg::CAP_W-1:0]      cfg_capacity
);

  localparam int IDX_W  = lfuc_pkg::IDX_W;
  localparam int OCC_W  = lfuc_pkg::OCC_W;
  localparam int WIDE_W = lfuc_pkg::WIDE_W;

  // ------------------------------------------------------------------
  // Entry memory: one write port, one registered read port
  // ------------------------------------------------------------------
  lfuc_pkg::entry_t mem_r [lfuc_pkg::DEPTH];
  lfuc_pkg::entry_t rd_q_r;
  logic             mem_rd_en;
  logic [IDX_W-1:0] mem_rd_addr;
  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  lfuc_pkg::entry_t mem_wr_data;

  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      mem_r[mem_wr_addr] <= mem_wr_data;
    end
    if (mem_rd_en) begin
      rd_q_r <= mem_r[mem_rd_addr];
    end
  end

  // ------------------------------------------------------------------
  // Control and working registers
  // ------------------------------------------------------------------
  lfuc_pkg::state_t               state_r, state_nxt;
  logic [lfuc_pkg::CAP_W-1:0]     cap_r;
  logic [OCC_W-1:0]               occ_r, occ_nxt;
  logic [OCC_W-1:0]               ptr_r, ptr_nxt;       // next address to read
  logic                           chk_vld_r, chk_vld_nxt; // rd_q_r holds a fresh read
  logic [IDX_W-1:0]               chk_idx_r, chk_idx_nxt; // address of rd_q_r
  logic                           iss_done_r, iss_done_nxt;
  logic                           dn_r, dn_nxt;         // shift towards the tail
  logic [IDX_W-1:0]               m_r, m_nxt;           // matched position
  logic [IDX_W-1:0]               dst_r, dst_nxt;       // final position
  lfuc_pkg::entry_t               s_r, s_nxt;           // matched entry, count raised
  logic                           res_found_r, res_found_nxt;
  logic [lfuc_pkg::ACT_W-1:0]     req_act_r;
  logic [lfuc_pkg::TAG_W-1:0]     req_tag_r;
  logic [lfuc_pkg::OFF_W-1:0]     req_off_r;

  logic                           out_valid_r;
  logic                           out_found_r;
  logic [lfuc_pkg::TAG_W-1:0]     out_tag_r;
  logic [lfuc_pkg::OFF_W-1:0]     out_off_r;
  logic [lfuc_pkg::BODY_W-1:0]    out_body_r;
  logic [lfuc_pkg::RANK_W-1:0]    out_rank_r;

  logic in_acc;
  logic out_free;
  logic cfg_acc;

  assign in_stall  = (state_r != lfuc_pkg::ST_IDLE);
  assign cfg_ready = (state_r == lfuc_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || !out_stall;

  // Effective capacity: zero counts as one, anything above DEPTH saturates
  logic [WIDE_W-1:0] cap_wide;
  logic [OCC_W-1:0]  eff_cap;

  always_comb begin
    cap_wide = WIDE_W'(cap_r);
    if (cap_r == '0) begin
      eff_cap = OCC_W'(1);
    end else if (cap_wide > WIDE_W'(lfuc_pkg::DEPTH)) begin
      eff_cap = OCC_W'(lfuc_pkg::DEPTH);
    end else begin
      eff_cap = OCC_W'(cap_wide);
    end
  end

  // Comparisons on the freshly read entry
  logic key_eq;
  logic scan_hit;
  logic scan_end;
  logic cnt_lower;
  logic shift_last;
  logic [IDX_W-1:0] lower_dst;

  always_comb begin
    if (req_act_r == lfuc_pkg::ACT_SRCH_TAG) begin
      key_eq = (rd_q_r.tag == req_tag_r);
    end else begin
      key_eq = (rd_q_r.off == req_off_r);
    end
  end

  assign scan_hit   = chk_vld_r && key_eq;
  assign scan_end   = !chk_vld_r && (ptr_r == occ_r);
  assign cnt_lower  = chk_vld_r && (chk_idx_r != m_r) && (rd_q_r.cnt < s_r.cnt);
  assign shift_last = chk_vld_r && (chk_idx_r == dst_r);
  // an entry ahead of the match takes its place; one behind it leaves room before it
  assign lower_dst  = (chk_idx_r < m_r) ? chk_idx_r : chk_idx_r - IDX_W'(1);

  // ------------------------------------------------------------------
  // Next state
  // ------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lfuc_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_action inside {lfuc_pkg::ACT_SRCH_TAG, lfuc_pkg::ACT_SRCH_OFF}) begin
            state_nxt = lfuc_pkg::ST_SCAN;
          end else begin
            state_nxt = lfuc_pkg::ST_RESP;
          end
        end
      end
      lfuc_pkg::ST_SCAN: begin
        if (scan_hit) begin
          state_nxt = lfuc_pkg::ST_RANK;
        end else if (scan_end) begin
          state_nxt = lfuc_pkg::ST_RESP;
        end
      end
      lfuc_pkg::ST_RANK: begin
        if (cnt_lower) begin
          state_nxt = (lower_dst != m_r) ? lfuc_pkg::ST_SHIFT : lfuc_pkg::ST_PLACE;
        end else if (scan_end) begin
          state_nxt = lfuc_pkg::ST_PLACE;
        end
      end
      lfuc_pkg::ST_SHIFT: begin
        if (shift_last) begin
          state_nxt = lfuc_pkg::ST_PLACE;
        end
      end
      lfuc_pkg::ST_PLACE: begin
        state_nxt = lfuc_pkg::ST_RESP;
      end
      lfuc_pkg::ST_RESP: begin
        if (out_free) begin
          state_nxt = lfuc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lfuc_pkg::ST_IDLE;
      end
    endcase
  end

  // ------------------------------------------------------------------
  // Memory controls and working values
  // ------------------------------------------------------------------
  always_comb begin
    mem_rd_en     = 1'b0;
    mem_rd_addr   = ptr_r[IDX_W-1:0];
    mem_wr_en     = 1'b0;
    mem_wr_addr   = dst_r;
    mem_wr_data   = s_r;
    ptr_nxt       = ptr_r;
    chk_vld_nxt   = 1'b0;
    chk_idx_nxt   = ptr_r[IDX_W-1:0];
    iss_done_nxt  = iss_done_r;
    dn_nxt        = dn_r;
    m_nxt         = m_r;
    dst_nxt       = dst_r;
    s_nxt         = s_r;
    res_found_nxt = res_found_r;
    occ_nxt       = occ_r;

    case (state_r)
      lfuc_pkg::ST_IDLE: begin
        if (in_acc) begin
          ptr_nxt       = '0;
          res_found_nxt = 1'b0;
          if (in_action == lfuc_pkg::ACT_ADD) begin
            // append while below capacity, else overwrite the tail
            mem_wr_en        = 1'b1;
            mem_wr_data.tag  = in_name_tag;
            mem_wr_data.off  = in_record_offset;
            mem_wr_data.body = in_payload;
            mem_wr_data.cnt  = '0;
            if (occ_r < eff_cap) begin
              mem_wr_addr = occ_r[IDX_W-1:0];
              occ_nxt     = occ_r + OCC_W'(1);
            end else begin
              mem_wr_addr = IDX_W'(occ_r - OCC_W'(1));
            end
          end
        end
      end
      lfuc_pkg::ST_SCAN, lfuc_pkg::ST_RANK: begin
        if (ptr_r < occ_r) begin
          mem_rd_en   = 1'b1;
          chk_vld_nxt = 1'b1;
          ptr_nxt     = ptr_r + OCC_W'(1);
        end
        if (state_r == lfuc_pkg::ST_SCAN && scan_hit) begin
          // raise the count, saturating, and restart the walk for the rank
          m_nxt         = chk_idx_r;
          dst_nxt       = chk_idx_r;
          s_nxt         = rd_q_r;
          s_nxt.cnt     = (rd_q_r.cnt == lfuc_pkg::CNT_MAX) ? rd_q_r.cnt
                                                            : rd_q_r.cnt + 1'b1;
          res_found_nxt = 1'b1;
          ptr_nxt       = '0;
          chk_vld_nxt   = 1'b0;
        end
        if (state_r == lfuc_pkg::ST_RANK && cnt_lower) begin
          dst_nxt      = lower_dst;
          dn_nxt       = (chk_idx_r < m_r);
          iss_done_nxt = 1'b0;
          chk_vld_nxt  = 1'b0;
          if (chk_idx_r < m_r) begin
            ptr_nxt = OCC_W'(m_r) - OCC_W'(1);
          end else begin
            ptr_nxt = OCC_W'(m_r) + OCC_W'(1);
          end
        end
      end
      lfuc_pkg::ST_SHIFT: begin
        // read one entry, write it one place over in the next cycle
        if (!iss_done_r) begin
          mem_rd_en   = 1'b1;
          chk_vld_nxt = 1'b1;
          if (ptr_r[IDX_W-1:0] == dst_r) begin
            iss_done_nxt = 1'b1;
          end else if (dn_r) begin
            ptr_nxt = ptr_r - OCC_W'(1);
          end else begin
            ptr_nxt = ptr_r + OCC_W'(1);
          end
        end
        if (chk_vld_r) begin
          mem_wr_en   = 1'b1;
          mem_wr_data = rd_q_r;
          mem_wr_addr = dn_r ? chk_idx_r + IDX_W'(1) : chk_idx_r - IDX_W'(1);
        end
      end
      lfuc_pkg::ST_PLACE: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = dst_r;
        mem_wr_data = s_r;
      end
      lfuc_pkg::ST_RESP: begin
        // hold until the output register frees
      end
      default: begin
      end
    endcase
  end

  // ------------------------------------------------------------------
  // Registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lfuc_pkg::ST_IDLE;
      cap_r       <= lfuc_pkg::CAP_RESET;
      occ_r       <= '0;
      chk_vld_r   <= 1'b0;
      iss_done_r  <= 1'b0;
      res_found_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      chk_vld_r   <= chk_vld_nxt;
      iss_done_r  <= iss_done_nxt;
      res_found_r <= res_found_nxt;
      if (cfg_acc) begin
        cap_r <= cfg_capacity;
      end
      if (state_r == lfuc_pkg::ST_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r     <= ptr_nxt;
    chk_idx_r <= chk_idx_nxt;
    dn_r      <= dn_nxt;
    m_r       <= m_nxt;
    dst_r     <= dst_nxt;
    s_r       <= s_nxt;
    if (in_acc) begin
      req_act_r <= in_action;
      req_tag_r <= in_name_tag;
      req_off_r <= in_record_offset;
    end
    // load the result; a miss, an add or an unused action reads as all zero
    if (state_r == lfuc_pkg::ST_RESP && out_free) begin
      out_found_r <= res_found_r;
      out_tag_r   <= res_found_r ? s_r.tag  : '0;
      out_off_r   <= res_found_r ? s_r.off  : '0;
      out_body_r  <= res_found_r ? s_r.body : '0;
      out_rank_r  <= res_found_r ? lfuc_pkg::RANK_W'(dst_r) : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_found_name_tag = out_tag_r;
  assign out_found_offset   = out_off_r;
  assign out_found_payload  = out_body_r;
  assign out_new_rank       = out_rank_r;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  // The shift walk never reads the entry it writes in the same cycle
  a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_rd_en && mem_wr_en) |-> (mem_rd_addr != mem_wr_addr))
    else $error("read and write of the same entry in one cycle");

  // Occupancy stays within the memory
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(lfuc_pkg::DEPTH))
    else $error("occupancy beyond depth");

  // A new result appears only out of the response state
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && out_stall)) |-> $past(state_r == lfuc_pkg::ST_RESP))
    else $error("result loaded outside the response state");

  // An accepted transaction always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != lfuc_pkg::ST_IDLE))
    else $error("accepted transaction left the sequencer idle");

  // The final position lies inside the occupied range once a match is placed
  a_place_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lfuc_pkg::ST_PLACE) |-> (OCC_W'(dst_r) < occ_r))
    else $error("placement beyond occupancy");

endmodule

// ===== sim/tb_lfu_ordered_record_cache_top.sv =====
// Self-checking testbench for the use-count ordered record cache.
// Depends on rtl/lfuc_pkg.sv and rtl/lfu_ordered_record_cache_top.sv.
// Predicts every result from a shadow copy of the cache and checks them in order.
`timescale 1ns / 1ps

module tb_lfu_ordered_record_cache_top;
  import lfuc_pkg::*;

  // Action code that the block must treat as a no-op with an all-zero result
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  // Settle time once drained, set above the worst search
  localparam int SETTLE      = 3 * DEPTH + 8;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int RANDOM_PER_PHASE = 85;
  localparam int HEAD_ROUNDS = 20;

  typedef struct {
    logic [ACT_W-1:0]  action;
    logic [TAG_W-1:0]  name_tag;
    logic [OFF_W-1:0]  record_offset;
    logic [BODY_W-1:0] payload;
  } cache_req_t;

  typedef struct {
    logic              found;
    logic [TAG_W-1:0]  name_tag;
    logic [OFF_W-1:0]  offset;
    logic [BODY_W-1:0] payload;
    logic [RANK_W-1:0] rank;
  } lookup_result_t;

  // Clock, reset and every block input start at a known value
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid         = 1'b0;
  logic [ACT_W-1:0]  in_action        = ACT_ADD;
  logic [TAG_W-1:0]  in_name_tag      = '0;
  logic [OFF_W-1:0]  in_record_offset = '0;
  logic [BODY_W-1:0] in_payload       = '0;
  logic              out_stall        = 1'b0;
  logic              cfg_valid        = 1'b0;
  logic [CAP_W-1:0]  cfg_capacity     = CAP_RESET;

  logic              in_stall;
  logic              out_valid;
  logic              out_found;
  logic [TAG_W-1:0]  out_found_name_tag;
  logic [OFF_W-1:0]  out_found_offset;
  logic [BODY_W-1:0] out_found_payload;
  logic [RANK_W-1:0] out_new_rank;
  logic              cfg_ready;

  // Shadow of the cache contents, in rank order with the head at index 0
  logic [CAP_W-1:0] capacity_shadow = CAP_RESET;
  int               occupied        = 0;
  entry_t           cache_rows[DEPTH];

  lookup_result_t pending_lookups[$];
  lookup_result_t oldest_lookup;
  int             mismatches = 0;

  // Traffic shaping shared between the test tasks and the receiver
  bit tx_eager  = 1'b0;
  bit rx_eager  = 1'b0;
  bit hold_req  = 1'b0;
  int hold_left = 0;
  int burst_left = 0;
  int seg_left  = 0;
  int stall_pct = 0;
  int cycle_count = 0;

  lfu_ordered_record_cache_top u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_name_tag        (in_name_tag),
    .in_record_offset   (in_record_offset),
    .in_payload         (in_payload),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_found          (out_found),
    .out_found_name_tag (out_found_name_tag),
    .out_found_offset   (out_found_offset),
    .out_found_payload  (out_found_payload),
    .out_new_rank       (out_new_rank),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_capacity       (cfg_capacity)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction: apply one accepted transaction to the shadow and return what
  // the block must answer. Adds, misses and the unused action give all zeros.
  // ---------------------------------------------------------------------------
  function automatic lookup_result_t apply_to_cache(cache_req_t r);
    lookup_result_t res;
    entry_t         moved;
    int             limit;
    int             slot;
    int             hit;
    int             lower;
    int             dst;
    res = '{found: 1'b0, name_tag: '0, offset: '0, payload: '0, rank: '0};
    limit = (capacity_shadow == 0) ? 1 :
            ((capacity_shadow > DEPTH) ? DEPTH : int'(capacity_shadow));
    case (r.action)
      ACT_ADD: begin
        // Append while there is room, otherwise overwrite the current tail
        if (occupied < limit) begin
          slot = occupied;
          occupied++;
        end else begin
          slot = (occupied == 0) ? 0 : occupied - 1;
          if (occupied == 0) occupied = 1;
        end
        if (slot >= DEPTH) slot = DEPTH - 1;
        cache_rows[slot] = '{tag: r.name_tag, off: r.record_offset,
                             body: r.payload, cnt: '0};
      end
      ACT_SRCH_TAG, ACT_SRCH_OFF: begin
        // First match from the head wins, so duplicate keys hide later entries
        hit = -1;
        for (int i = 0; i < occupied; i++) begin
          if (hit < 0) begin
            if (r.action == ACT_SRCH_TAG ? (cache_rows[i].tag == r.name_tag)
                                         : (cache_rows[i].off == r.record_offset))
              hit = i;
          end
        end
        if (hit >= 0) begin
          // Count up, saturating at the top of the counter
          if (cache_rows[hit].cnt != CNT_MAX)
            cache_rows[hit].cnt = cache_rows[hit].cnt + 1'b1;
          moved = cache_rows[hit];
          lower = -1;
          for (int i = 0; i < occupied; i++) begin
            if (lower < 0 && cache_rows[i].cnt < moved.cnt) lower = i;
          end
          dst = hit;
          if (lower >= 0 && lower < hit) begin
            // Slide the displaced run one place towards the tail
            for (int k = hit; k > lower; k--) cache_rows[k] = cache_rows[k-1];
            dst = lower;
          end else if (lower > hit) begin
            // Land just before the first lower count; close the gap behind
            dst = lower - 1;
            for (int k = hit; k < dst; k++) cache_rows[k] = cache_rows[k+1];
          end
          cache_rows[dst] = moved;
          res = '{found: 1'b1, name_tag: moved.tag, offset: moved.off,
                  payload: moved.body, rank: dst[RANK_W-1:0]};
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic cache_req_t make_req(logic [ACT_W-1:0] action, logic [TAG_W-1:0] tag,
                                          logic [OFF_W-1:0] off, logic [BODY_W-1:0] body);
    cache_req_t r;
    r.action        = action;
    r.name_tag      = tag;
    r.record_offset = off;
    r.payload       = body;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly searches for keys that are present, so that counts grow and entries
  // move; the rest are adds (some with a duplicate key), misses and no-ops.
  function automatic cache_req_t random_request();
    cache_req_t r;
    int         pick;
    int         row;
    r = make_req(ACT_ADD, rand64(), $urandom, rand64());
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      if (occupied > 0 && $urandom_range(0, 7) == 0) begin
        row = $urandom_range(0, occupied - 1);
        r.name_tag = cache_rows[row].tag;
      end
    end else if (pick < 85 && occupied > 0) begin
      row = $urandom_range(0, occupied - 1);
      if ($urandom_range(0, 1) == 1) begin
        r.action   = ACT_SRCH_TAG;
        r.name_tag = cache_rows[row].tag;
      end else begin
        r.action        = ACT_SRCH_OFF;
        r.record_offset = cache_rows[row].off;
      end
    end else if (pick < 95) begin
      r.action = ($urandom_range(0, 1) == 1) ? ACT_SRCH_TAG : ACT_SRCH_OFF;
    end else begin
      r.action = ACT_UNUSED;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Present one transaction and hold it until taken; valid stays high after.
  task automatic send_item(input cache_req_t r);
    in_valid         <= 1'b1;
    in_action        <= r.action;
    in_name_tag      <= r.name_tag;
    in_record_offset <= r.record_offset;
    in_payload       <= r.payload;
    do @(posedge clk); while (in_stall);
    pending_lookups = {pending_lookups, apply_to_cache(r)};
  endtask

  // Send in bursts of random length, with random gaps between bursts.
  task automatic offer(input cache_req_t r);
    int gap;
    send_item(r);
    if (!tx_eager) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap = $urandom_range(1, 8);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 30)
                                                 : $urandom_range(0, 5);
      end
    end
  endtask

  // Drop valid and wait until every predicted result has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write the capacity register once the block is idle.
  task automatic write_capacity(input int value);
    wait_drained();
    cfg_valid    <= 1'b1;
    cfg_capacity <= value[CAP_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid       <= 1'b0;
    capacity_shadow = value[CAP_W-1:0];
  endtask

  // ---------------------------------------------------------------------------
  // Result side: receiver stall pattern, long hold-off and the checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rx_eager) begin
      out_stall <= 1'b0;
    end else begin
      // Change the stall density every segment; some segments never stall
      if (seg_left == 0) begin
        seg_left = $urandom_range(4, 40);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      seg_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Compare each taken result with the oldest prediction, field by field.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_lookups.size() == 0) begin
        $error("result transaction with no prediction waiting");
        mismatches++;
      end else begin
        oldest_lookup = pending_lookups.pop_front();
        if (out_found !== oldest_lookup.found) begin
          $error("found: expected %0h, got %0h", oldest_lookup.found, out_found);
          mismatches++;
        end
        if (out_found_name_tag !== oldest_lookup.name_tag) begin
          $error("found_name_tag: expected %h, got %h",
                 oldest_lookup.name_tag, out_found_name_tag);
          mismatches++;
        end
        if (out_found_offset !== oldest_lookup.offset) begin
          $error("found_offset: expected %h, got %h", oldest_lookup.offset, out_found_offset);
          mismatches++;
        end
        if (out_found_payload !== oldest_lookup.payload) begin
          $error("found_payload: expected %h, got %h",
                 oldest_lookup.payload, out_found_payload);
          mismatches++;
        end
        if (out_new_rank !== oldest_lookup.rank) begin
          $error("new_rank: expected %0d, got %0d", oldest_lookup.rank, out_new_rank);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run if it goes far beyond the slowest correct run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, both search kinds, misses (also on an empty cache), the
  // unused action and a duplicate name tag that stays hidden behind the first.
  task automatic test_add_and_search();
    offer(make_req(ACT_SRCH_TAG, '0, '0, rand64()));
    offer(make_req(ACT_ADD, '0, '0, '1));
    offer(make_req(ACT_ADD, '1, '1, '0));
    offer(make_req(ACT_ADD, 64'hA5A5_5A5A_0F0F_F0F0, 32'h8000_0001, rand64()));
    offer(make_req(ACT_SRCH_TAG, '1, $urandom, rand64()));
    offer(make_req(ACT_SRCH_OFF, rand64(), '0, rand64()));
    offer(make_req(ACT_SRCH_TAG, 64'h1234_5678_9ABC_DEF0, $urandom, rand64()));
    offer(make_req(ACT_SRCH_OFF, rand64(), 32'hFFFF_FFFE, rand64()));
    offer(make_req(ACT_UNUSED, '1, '1, '1));
    offer(make_req(ACT_ADD, '1, 32'h0000_7777, 64'hDEAD_BEEF_CAFE_F00D));
    offer(make_req(ACT_SRCH_TAG, '1, $urandom, rand64()));
    offer(make_req(ACT_SRCH_OFF, rand64(), 32'h8000_0001, rand64()));
  endtask

  // Capacity of zero acts as one and a too-large capacity as DEPTH; with the
  // occupancy above a lowered capacity an add replaces the tail.
  task automatic test_capacity_limits();
    logic [TAG_W-1:0] tail_tag;
    logic [OFF_W-1:0] tail_off;
    tail_tag = rand64();
    tail_off = $urandom;
    write_capacity(0);
    offer(make_req(ACT_ADD, tail_tag, $urandom, rand64()));
    offer(make_req(ACT_SRCH_TAG, tail_tag, $urandom, rand64()));
    write_capacity(31);
    offer(make_req(ACT_ADD, rand64(), $urandom, rand64()));
    offer(make_req(ACT_ADD, rand64(), tail_off, rand64()));
    offer(make_req(ACT_SRCH_OFF, rand64(), tail_off, rand64()));
  endtask

  // Hold the receiver off for a long stretch while the sender keeps offering,
  // so the block fills and stalls its input; then pause until all have come.
  task automatic test_backpressure();
    write_capacity(16);
    tx_eager = 1'b1;
    hold_req = 1'b1;
    repeat (10) send_item(random_request());
    tx_eager = 1'b0;
    wait_drained();
  endtask

  // Random traffic over several capacity settings, extremes included.
  task automatic test_random_traffic();
    int plan[6] = '{16, 1, 5, 31, 0, 9};
    plan[5] = $urandom_range(2, 15);
    foreach (plan[p]) begin
      write_capacity(plan[p]);
      repeat (RANDOM_PER_PHASE) offer(random_request());
    end
  endtask

  // Search the head entry back to back, so its count keeps climbing while it
  // stays at the head.
  task automatic test_repeated_head_search();
    cache_req_t r;
    wait_drained();
    r = make_req(ACT_SRCH_TAG, cache_rows[0].tag, $urandom, rand64());
    tx_eager = 1'b1;
    rx_eager = 1'b1;
    repeat (HEAD_ROUNDS) send_item(r);
    tx_eager = 1'b0;
    rx_eager = 1'b0;
    wait_drained();
  endtask

  initial begin
    foreach (cache_rows[i]) cache_rows[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_add_and_search();
    test_capacity_limits();
    test_backpressure();
    test_random_traffic();
    test_repeated_head_search();

    wait_drained();
    if (mismatches == 0 && pending_lookups.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
